### hdl/rss_pkg.sv
`timescale 1ns / 1ps

package rss_pkg;

  localparam int DATA_W    = 32;
  localparam int LEN_W     = 11;
  localparam int IDX_W     = 10;
  localparam int POS_W     = 10;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int DEPTH_DEF = 1024;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP_LO,
    S_CMP_HI
  } rss_state_t;

  typedef struct packed {
    logic hit;
    logic left_sorted;
    logic left_move_hi;
    logic right_move_hi;
  } rss_dec_t;

endpackage

### hdl/rotated_sorted_search.sv
`timescale 1ns / 1ps

// Binary search over a rotated sorted table of signed 32-bit words held in a
// two-read-port RAM. start is taken when busy is low. A write command stores
// one word in that cycle and returns nothing; a write index at or above DEPTH
// is dropped. A search command runs probes: the midpoint and low bound are
// read together, then compared, and when the left half is not sorted the high
// bound is also read and compared. Probe speed is bounded by the RAM read
// latency and the single compare unit. The result shows on
// out_found/out_position for one cycle with out_valid and cannot be held off
// by the receiver; busy drops in that same cycle. Length is set through the
// APB register at address 0 and saturates at DEPTH; write it only while busy
// is low.

module rotated_sorted_search #(
  parameter int DEPTH = rss_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_command,
  input  logic [rss_pkg::IDX_W-1:0]           in_write_index,
  input  logic signed [rss_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [rss_pkg::POS_W-1:0]           out_position,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rss_pkg::PADDR_W-1:0]         paddr,
  input  logic [rss_pkg::PDATA_W-1:0]         pwdata,
  output logic [rss_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 2;

  rss_pkg::rss_state_t state_r, state_nxt;

  logic [rss_pkg::LEN_W-1:0]          len_r;
  logic signed [CW-1:0]               lo_r, lo_nxt;
  logic signed [CW-1:0]               hi_r, hi_nxt;
  logic signed [CW-1:0]               mid_r, mid_nxt;
  logic signed [rss_pkg::DATA_W-1:0]  target_r, target_nxt;
  logic signed [rss_pkg::DATA_W-1:0]  vm_r, vm_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_found_r, out_found_nxt;
  logic [rss_pkg::POS_W-1:0]          out_position_r, out_position_nxt;

  logic signed [CW-1:0]               n_sat;
  logic signed [CW:0]                 mid_sum;
  logic signed [CW-1:0]               mid_c;
  logic signed [CW-1:0]               step_lo, step_hi;
  logic                               move_hi;

  logic                               ram_we;
  logic [AW-1:0]                      ram_raddr_a, ram_raddr_b;
  logic [rss_pkg::DATA_W-1:0]         ram_rdata_a, ram_rdata_b;
  logic signed [rss_pkg::DATA_W-1:0]  vm_sel;
  rss_pkg::rss_dec_t                  dec;

  logic cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_wr && (paddr[2] == rss_pkg::REG_LENGTH)) begin
      len_r <= pwdata[rss_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == rss_pkg::REG_LENGTH) begin
      prdata = rss_pkg::PDATA_W'(len_r);
    end
  end

  // search bounds
  assign n_sat   = (32'(len_r) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(len_r);
  assign mid_sum = {lo_r[CW-1], lo_r} + {hi_r[CW-1], hi_r};
  assign mid_c   = mid_sum[CW:1];
  assign step_lo = mid_r + CW'(1);
  assign step_hi = mid_r - CW'(1);

  assign ram_we = (state_r == rss_pkg::S_IDLE) && start &&
                  (in_command == rss_pkg::CMD_WRITE) &&
                  (32'(in_write_index) < 32'(DEPTH));

  assign vm_sel = (state_r == rss_pkg::S_CMP_LO) ? signed'(ram_rdata_a) : vm_r;

  rss_ram #(
    .WIDTH (rss_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (AW'(in_write_index)),
    .wdata   (in_value),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  rss_narrow u_narrow (
    .target (target_r),
    .vm     (vm_sel),
    .vl     (signed'(ram_rdata_b)),
    .vh     (signed'(ram_rdata_a)),
    .dec    (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rss_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r           <= lo_nxt;
    hi_r           <= hi_nxt;
    mid_r          <= mid_nxt;
    target_r       <= target_nxt;
    vm_r           <= vm_nxt;
    out_found_r    <= out_found_nxt;
    out_position_r <= out_position_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    mid_nxt          = mid_r;
    target_nxt       = target_r;
    vm_nxt           = vm_r;
    out_valid_nxt    = 1'b0;
    out_found_nxt    = out_found_r;
    out_position_nxt = out_position_r;
    ram_raddr_a      = AW'(mid_c);
    ram_raddr_b      = AW'(lo_r);
    move_hi          = 1'b0;

    case (state_r)
      rss_pkg::S_IDLE: begin
        if (start && (in_command == rss_pkg::CMD_SEARCH)) begin
          target_nxt = in_value;
          lo_nxt     = '0;
          hi_nxt     = n_sat - CW'(1);
          if (n_sat == '0) begin
            out_valid_nxt    = 1'b1;
            out_found_nxt    = 1'b0;
            out_position_nxt = '0;
          end else begin
            state_nxt = rss_pkg::S_READ;
          end
        end
      end
      rss_pkg::S_READ: begin
        mid_nxt   = mid_c;
        state_nxt = rss_pkg::S_CMP_LO;
      end
      rss_pkg::S_CMP_LO: begin
        ram_raddr_a = AW'(hi_r);
        vm_nxt      = signed'(ram_rdata_a);
        if (dec.hit) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = 1'b1;
          out_position_nxt = rss_pkg::POS_W'(mid_r);
          state_nxt        = rss_pkg::S_IDLE;
        end else if (dec.left_sorted) begin
          move_hi = dec.left_move_hi;
        end else begin
          state_nxt = rss_pkg::S_CMP_HI;
        end
      end
      rss_pkg::S_CMP_HI: begin
        move_hi = dec.right_move_hi;
      end
      default: begin
        state_nxt = rss_pkg::S_IDLE;
      end
    endcase

    // narrowing step shared by both compare states
    if (((state_r == rss_pkg::S_CMP_LO) && !dec.hit && dec.left_sorted) ||
        (state_r == rss_pkg::S_CMP_HI)) begin
      if (move_hi) begin
        hi_nxt = step_hi;
      end else begin
        lo_nxt = step_lo;
      end
      if (lo_nxt <= hi_nxt) begin
        state_nxt = rss_pkg::S_READ;
      end else begin
        state_nxt        = rss_pkg::S_IDLE;
        out_valid_nxt    = 1'b1;
        out_found_nxt    = 1'b0;
        out_position_nxt = '0;
      end
    end
  end

  assign busy         = (state_r != rss_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  a_busy_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_command == rss_pkg::CMD_SEARCH)))
    else $error("busy rose without an accepted search");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (lo_r <= hi_r) && (lo_r >= 0) && (hi_r < CW'(DEPTH)))
    else $error("search bounds out of order");

  a_miss_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_position == '0))
    else $error("miss with nonzero position");

  a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(busy)) |-> !busy)
    else $error("result while search still running");

endmodule

### hdl/rss_ram.sv
`timescale 1ns / 1ps

module rss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                         rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/rss_narrow.sv
`timescale 1ns / 1ps

module rss_narrow (
  input  logic signed [rss_pkg::DATA_W-1:0] target,
  input  logic signed [rss_pkg::DATA_W-1:0] vm,
  input  logic signed [rss_pkg::DATA_W-1:0] vl,
  input  logic signed [rss_pkg::DATA_W-1:0] vh,
  output rss_pkg::rss_dec_t                 dec
);

  always_comb begin
    dec.hit           = (vm == target);
    dec.left_sorted   = (vl <= vm);
    dec.left_move_hi  = (vl <= target) && (target < vm);
    dec.right_move_hi = !((vm < target) && (target <= vh));
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = rss_pkg::DEPTH_DEF;
  localparam int ITEM_GOAL = 1950;
  localparam int SETTLE = 40;
  localparam int CYCLE_LIMIT = 800000;
  localparam logic [rss_pkg::PADDR_W-1:0] ADDR_LENGTH = {rss_pkg::REG_LENGTH, 2'b00};
  localparam logic [rss_pkg::PADDR_W-1:0] ADDR_SPARE = {~rss_pkg::REG_LENGTH, 2'b00};
  localparam int INT_MIN = 32'sh8000_0000;
  localparam int INT_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic found;
    logic [rss_pkg::POS_W-1:0] position;
  } answer_t;

  class table_search_tracker;
    int table_words[DEPTH];
    logic [rss_pkg::LEN_W-1:0] span_len = '0;
    answer_t pending_answers[$];
    int mismatches;
    int searches;
    int hits;

    task log_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void write_reg(logic idx, logic [rss_pkg::PDATA_W-1:0] data);
      if (idx == rss_pkg::REG_LENGTH) span_len = data[rss_pkg::LEN_W-1:0];
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction

    // binary search over the rotated table, one probe per loop pass
    function void take_word(logic cmd, logic [rss_pkg::IDX_W-1:0] idx,
                            logic signed [rss_pkg::DATA_W-1:0] val);
      int n, lo, hi, mid, vm, vl, vh, target;
      answer_t ans;
      if (cmd == rss_pkg::CMD_WRITE) begin
        if (idx < DEPTH) table_words[idx] = val;
        return;
      end
      target = val;
      n = (span_len > DEPTH) ? DEPTH : int'(span_len);
      lo = 0;
      hi = n - 1;
      ans = '0;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        vm = table_words[mid];
        vl = table_words[lo];
        vh = table_words[hi];
        if (vm == target) begin
          ans.found = 1'b1;
          ans.position = mid[rss_pkg::POS_W-1:0];
          break;
        end
        if (vl <= vm) begin
          if (vl <= target && target < vm) hi = mid - 1;
          else lo = mid + 1;
        end else begin
          if (vm < target && target <= vh) lo = mid + 1;
          else hi = mid - 1;
        end
      end
      pending_answers.push_back(ans);
      searches++;
    endfunction

    task check_answer(logic found, logic [rss_pkg::POS_W-1:0] position);
      answer_t want;
      if (pending_answers.size() == 0) begin
        log_mismatch($sformatf("result found=%0b position=%0d with no search pending",
                               found, position));
      end else begin
        want = pending_answers.pop_front();
        if (found !== want.found)
          log_mismatch($sformatf("found %0b, predicted %0b", found, want.found));
        if (position !== want.position)
          log_mismatch($sformatf("position %0d, predicted %0d", position, want.position));
        if (want.found) hits++;
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_command;
  logic [rss_pkg::IDX_W-1:0] in_write_index;
  logic signed [rss_pkg::DATA_W-1:0] in_value;
  logic out_valid;
  logic out_found;
  logic [rss_pkg::POS_W-1:0] out_position;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rss_pkg::PADDR_W-1:0] paddr;
  logic [rss_pkg::PDATA_W-1:0] pwdata;
  logic [rss_pkg::PDATA_W-1:0] prdata;
  logic pready;

  table_search_tracker sb;
  int cycles;
  int words_in;
  int reg_writes;
  bit steady;
  bit free_writes;

  rotated_sorted_search #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_write_index(in_write_index),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_found(out_found),
    .out_position(out_position),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL rotated_sorted_search");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_answer(out_found, out_position);
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_word(logic cmd, logic [rss_pkg::IDX_W-1:0] idx,
                           logic signed [rss_pkg::DATA_W-1:0] val);
    int gap;
    @(negedge clk);
    start = 1'b1;
    in_command = cmd;
    in_write_index = idx;
    in_value = val;
    do @(posedge clk); while (busy);
    sb.take_word(cmd, idx, val);
    words_in++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      in_command = 1'($urandom);
      in_write_index = rss_pkg::IDX_W'($urandom);
      in_value = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic apb_write(logic [rss_pkg::PADDR_W-1:0] addr,
                           logic [rss_pkg::PDATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr[2], data);
    reg_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = rss_pkg::PADDR_W'($urandom);
    pwdata = $urandom;
  endtask

  task automatic set_length(logic [rss_pkg::LEN_W-1:0] len);
    logic [rss_pkg::PDATA_W-1:0] data;
    data = $urandom_range(0, 1) ? $urandom : '0;
    data[rss_pkg::LEN_W-1:0] = len;
    wait_idle();
    apb_write(ADDR_LENGTH, data);
  endtask

  // n distinct ascending words, rotated by a random amount
  task automatic load_rotated(int n);
    longint step_max, span, cur;
    int turn;
    int vals[$];
    if (n == 0) return;
    step_max = ($urandom_range(0, 2) == 0) ? 64'd4 : 64'd4294967295 / n;
    span = 64'd4294967295 - n * step_max;
    cur = -64'sd2147483648 + longint'($urandom_range(0, 32'(span)));
    for (int i = 0; i < n; i++) begin
      vals.push_back(int'(cur));
      cur += longint'($urandom_range(1, 32'(step_max)));
    end
    turn = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++)
      send_word(rss_pkg::CMD_WRITE, rss_pkg::IDX_W'(i), vals[(i + turn) % n]);
  endtask

  task automatic run_searches(int count);
    int n, pick, tgt;
    for (int k = 0; k < count; k++) begin
      n = (sb.span_len > DEPTH) ? DEPTH : int'(sb.span_len);
      if (free_writes && $urandom_range(0, 11) == 0) begin
        send_word(rss_pkg::CMD_WRITE, rss_pkg::IDX_W'($urandom), $urandom);
      end else begin
        pick = $urandom_range(0, 9);
        if (n > 0 && pick < 5) begin
          tgt = sb.table_words[$urandom_range(0, n - 1)];
        end else if (n > 0 && pick < 7) begin
          tgt = sb.table_words[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        end else if (pick == 7) begin
          case ($urandom_range(0, 2))
            0: tgt = INT_MIN;
            1: tgt = INT_MAX;
            default: tgt = 0;
          endcase
        end else begin
          tgt = $urandom;
        end
        send_word(rss_pkg::CMD_SEARCH, rss_pkg::IDX_W'($urandom), tgt);
      end
    end
  endtask

  initial begin
    int r, n;
    sb = new();
    cycles = 0;
    words_in = 0;
    reg_writes = 0;
    steady = 1'b0;
    free_writes = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = rss_pkg::CMD_WRITE;
    in_write_index = '0;
    in_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table: every search misses, then a one-word table
    send_word(rss_pkg::CMD_SEARCH, '0, 0);
    send_word(rss_pkg::CMD_SEARCH, '1, INT_MIN);
    send_word(rss_pkg::CMD_SEARCH, '0, INT_MAX);
    send_word(rss_pkg::CMD_WRITE, '1, INT_MAX);
    send_word(rss_pkg::CMD_WRITE, '0, INT_MIN);
    wait_idle();
    apb_write(ADDR_SPARE, $urandom);
    send_word(rss_pkg::CMD_SEARCH, '0, INT_MIN);
    set_length(rss_pkg::LEN_W'(1));
    send_word(rss_pkg::CMD_SEARCH, '0, INT_MIN);
    send_word(rss_pkg::CMD_SEARCH, '1, INT_MAX);
    // three words with the wrap between the two extremes
    send_word(rss_pkg::CMD_WRITE, rss_pkg::IDX_W'(0), 0);
    send_word(rss_pkg::CMD_WRITE, rss_pkg::IDX_W'(1), INT_MAX);
    send_word(rss_pkg::CMD_WRITE, rss_pkg::IDX_W'(2), INT_MIN);
    set_length(rss_pkg::LEN_W'(3));
    send_word(rss_pkg::CMD_SEARCH, '0, 0);
    send_word(rss_pkg::CMD_SEARCH, '0, INT_MAX);
    send_word(rss_pkg::CMD_SEARCH, '1, INT_MIN);
    send_word(rss_pkg::CMD_SEARCH, '0, -1);
    send_word(rss_pkg::CMD_SEARCH, '0, 1);
    set_length(rss_pkg::LEN_W'(2));
    send_word(rss_pkg::CMD_SEARCH, '0, INT_MIN);

    // full table, then lengths past the end of the store
    load_rotated(DEPTH);
    set_length(rss_pkg::LEN_W'(DEPTH));
    run_searches(60);
    set_length('1);
    run_searches(20);
    set_length(rss_pkg::LEN_W'(DEPTH + 1));
    run_searches(15);
    free_writes = 1'b1;

    while (words_in < ITEM_GOAL) begin
      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 19);
      if (r == 0) begin
        set_length(rss_pkg::LEN_W'($urandom_range(0, 2047)));
      end else if (r < 3) begin
        n = $urandom_range(17, 128);
        load_rotated(n);
        set_length(rss_pkg::LEN_W'(n));
      end else begin
        n = $urandom_range(0, 16);
        load_rotated(n);
        set_length(rss_pkg::LEN_W'(n));
      end
      run_searches($urandom_range(4, 24));
    end

    wait_idle();
    $display("covered %0d words in, %0d searches (%0d found), %0d register writes",
             words_in, sb.searches, sb.hits, reg_writes);
    $display("table sizes from empty to past the store end, with stray overwrites");
    if (sb.mismatches == 0) begin
      $display("PASS rotated_sorted_search");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAIL rotated_sorted_search");
    end
    $finish;
  end

endmodule
